// ===== rtl/core/bgs_pkg.sv =====
// Shared constants, types and codes of the bicubic grid sampler.
`timescale 1ns / 1ps
package bgs_pkg;
    localparam int MAX_COLS_DEF      = 256;
    localparam int MAX_ROWS_DEF      = 256;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int HEIGHT_W = 24;
    localparam int POS_W    = 17;
    localparam int REG_W    = 9;
    localparam int IDX_W    = 3;
    localparam int OUT_W    = 32;
    localparam int TAP_W    = 27;
    localparam int E_W      = 32;
    localparam int RES_W    = E_W + 1;

    localparam logic [IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SCALE_X     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SCALE_Y     = 3'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_LAST,
        ST_XSTART,
        ST_XWAIT,
        ST_YSTART,
        ST_YWAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CU_IDLE,
        CU_MUL,
        CU_ADD,
        CU_DONE
    } t_cu_state;
endpackage

// ===== rtl/core/bgs_cubic.sv =====
// Multi-cycle Catmull-Rom cubic evaluator with one shared multiplier.
`timescale 1ns / 1ps
module bgs_cubic #(
    parameter int POS_FRAC_BITS = bgs_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [bgs_pkg::TAP_W-1:0]  i_a,
    input  logic signed [bgs_pkg::TAP_W-1:0]  i_b,
    input  logic signed [bgs_pkg::TAP_W-1:0]  i_c,
    input  logic signed [bgs_pkg::TAP_W-1:0]  i_d,
    input  logic        [POS_FRAC_BITS-1:0]   i_t,
    output logic                              o_done,
    output logic signed [bgs_pkg::RES_W-1:0]  o_result
);
    localparam int EW  = bgs_pkg::E_W;
    localparam int TW  = bgs_pkg::TAP_W;
    localparam int PRW = EW + POS_FRAC_BITS + 1;
    localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (POS_FRAC_BITS - 1);

    bgs_pkg::t_cu_state r_state, n_state;
    logic signed [EW-1:0]  r_e, r_b2, r_c2;
    logic signed [TW-1:0]  r_b;
    logic [POS_FRAC_BITS-1:0] r_t;
    logic [1:0]            r_step;
    logic signed [PRW-1:0] r_prod;

    logic signed [EW-1:0]  a_x, b_x, c_x, d_x;
    logic signed [PRW-1:0] rnd_full;
    logic signed [EW-1:0]  addend;
    logic signed [EW:0]    e_half;

    assign a_x = EW'(i_a);
    assign b_x = EW'(i_b);
    assign c_x = EW'(i_c);
    assign d_x = EW'(i_d);
    assign rnd_full = (r_prod + HALF) >>> POS_FRAC_BITS;
    assign addend = (r_step == 2'd0) ? r_b2 : ((r_step == 2'd1) ? r_c2 : '0);
    assign e_half = ($signed({r_e[EW-1], r_e}) + (EW+1)'(1)) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgs_pkg::CU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bgs_pkg::CU_IDLE: begin
                if (i_start) begin
                    r_e    <= -a_x + 3 * b_x - 3 * c_x + d_x;
                    r_b2   <= 2 * a_x - 5 * b_x + 4 * c_x - d_x;
                    r_c2   <= c_x - a_x;
                    r_b    <= i_b;
                    r_t    <= i_t;
                    r_step <= 2'd0;
                end
            end
            bgs_pkg::CU_MUL: begin
                r_prod <= PRW'(r_e) * $signed({1'b0, r_t});
            end
            bgs_pkg::CU_ADD: begin
                r_e    <= rnd_full[EW-1:0] + addend;
                r_step <= r_step + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        o_done   = 1'b0;
        o_result = $signed({{(bgs_pkg::RES_W-TW){r_b[TW-1]}}, r_b}) + e_half;
        case (r_state)
            bgs_pkg::CU_IDLE: if (i_start) n_state = bgs_pkg::CU_MUL;
            bgs_pkg::CU_MUL:  n_state = bgs_pkg::CU_ADD;
            bgs_pkg::CU_ADD:  n_state = (r_step == 2'd2) ? bgs_pkg::CU_DONE : bgs_pkg::CU_MUL;
            bgs_pkg::CU_DONE: begin
                o_done  = 1'b1;
                n_state = bgs_pkg::CU_IDLE;
            end
            default: n_state = bgs_pkg::CU_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/bicubic_grid_sampler_top.sv =====
// Bicubic grid sampler: height memory, neighborhood sequencer and output register.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_op i_col i_row i_height i_u i_v
//   result    out        o_valid / i_stall   o_sample_value
//   config    in         i_cfg_wr_en         i_cfg_index i_cfg_wr_data
//
// A sample write leaves the input unstalled. A query holds o_stall high through a setup state,
// then for each of the four rows four reads from the height memory, a read-latency state and
// a run in the shared cubic unit, then the column pass in that unit and the load of the output
// register; no new transaction is taken until the query is back in the idle state.
// Reset clears control state and config registers, not the data registers or height memory.
// A result waits in the output register while i_stall is high; a new transaction is
// taken meanwhile, and a finished query waits for that register to free up.
`timescale 1ns / 1ps
module bicubic_grid_sampler_top #(
    parameter int MAX_COLS      = bgs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS      = bgs_pkg::MAX_ROWS_DEF,
    parameter int POS_FRAC_BITS = bgs_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic        [7:0]                   i_col,
    input  logic        [7:0]                   i_row,
    input  logic signed [bgs_pkg::HEIGHT_W-1:0] i_height,
    input  logic        [bgs_pkg::POS_W-1:0]    i_u,
    input  logic        [bgs_pkg::POS_W-1:0]    i_v,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bgs_pkg::OUT_W-1:0]    o_sample_value,
    input  logic                                i_cfg_wr_en,
    input  logic        [bgs_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic        [bgs_pkg::REG_W-1:0]    i_cfg_wr_data
);
    localparam int HW    = bgs_pkg::HEIGHT_W;
    localparam int TW    = bgs_pkg::TAP_W;
    localparam int RW    = bgs_pkg::REG_W;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RWD   = $clog2(MAX_ROWS);
    localparam int AW    = $clog2(MAX_COLS * MAX_ROWS);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int PW    = bgs_pkg::POS_W + RW + 1;
    localparam int XIW   = PW - POS_FRAC_BITS + 1;
    localparam int CRD   = XIW + 11;
    localparam logic signed [PW-1:0] HALFP = PW'(1) <<< (POS_FRAC_BITS - 1);

    logic [RW-1:0] r_grid_width, r_grid_height, r_scale_x, r_scale_y;

    bgs_pkg::t_state r_state, n_state;
    logic signed [XIW-1:0]         r_xi, r_yi;
    logic [POS_FRAC_BITS-1:0]      r_xf, r_yf;
    logic [bgs_pkg::POS_W-1:0]     r_u, r_v;
    logic [RW-1:0]                 r_xhi, r_yhi;
    logic [1:0]                    r_i, r_j, r_cap_slot;
    logic                          r_cap_en;
    logic signed [HW-1:0]          r_taps [4];
    logic signed [TW-1:0]          r_cols [4];
    logic signed [bgs_pkg::OUT_W-1:0] r_res;
    logic                          r_out_valid;
    logic signed [bgs_pkg::OUT_W-1:0] r_out_data;

    logic signed [HW-1:0] mem [DEPTH];
    logic signed [HW-1:0] r_rd_data;

    logic in_acc, wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [PW-1:0] xp, yp;
    logic signed [XIW-1:0] xi_c, yi_c;
    logic signed [CRD-1:0] cx, cy;
    logic [CW-1:0] col_cl;
    logic [RWD-1:0] row_cl;
    logic cu_start, cu_done, out_load;
    logic signed [TW-1:0] ta, tb, tc, td;
    logic [POS_FRAC_BITS-1:0] tt;
    logic signed [bgs_pkg::RES_W-1:0] cu_result;

    function automatic logic [RW-1:0] hi_bound(input logic [RW-1:0] reg_v, input int maxv);
        logic [RW+13:0] n;
        n = (RW+14)'(reg_v);
        if (n < (RW+14)'(1)) n = (RW+14)'(1);
        if (n > (RW+14)'(maxv)) n = (RW+14)'(maxv);
        return RW'(n - (RW+14)'(1));
    endfunction

    function automatic logic signed [XIW-1:0] trunc_pos(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q = mag >> POS_FRAC_BITS;
        return p[PW-1] ? -$signed(XIW'(q)) : $signed(XIW'(q));
    endfunction

    function automatic logic signed [CRD-1:0] clamp(input logic signed [CRD-1:0] c,
                                                    input logic [RW-1:0] hi);
        logic signed [CRD-1:0] h;
        h = $signed(CRD'(hi));
        if (c < 0) return '0;
        if (c > h) return h;
        return c;
    endfunction

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != bgs_pkg::ST_IDLE);
    assign wr_en   = in_acc && (i_op == bgs_pkg::OP_WRITE) &&
                     (13'(i_col) < 13'(MAX_COLS)) && (13'(i_row) < 13'(MAX_ROWS));
    assign wr_addr = AW'(AW'(i_row) * AW'(MAX_COLS) + AW'(i_col));

    assign xp   = $signed(PW'(r_u) * PW'(r_scale_x)) - HALFP;
    assign yp   = $signed(PW'(r_v) * PW'(r_scale_y)) - HALFP;
    assign xi_c = trunc_pos(xp);
    assign yi_c = trunc_pos(yp);

    assign cx     = clamp(CRD'(r_xi) - CRD'(1) + CRD'(r_i), r_xhi);
    assign cy     = clamp(CRD'(r_yi) - CRD'(1) + CRD'(r_j), r_yhi);
    assign col_cl = cx[CW-1:0];
    assign row_cl = cy[RWD-1:0];
    assign rd_en  = (r_state == bgs_pkg::ST_READ);
    assign rd_addr = AW'(AW'(row_cl) * AW'(MAX_COLS) + AW'(col_cl));

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= i_height;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 9'd256;
            r_grid_height <= 9'd256;
            r_scale_x     <= 9'd256;
            r_scale_y     <= 9'd256;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bgs_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wr_data;
                bgs_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wr_data;
                bgs_pkg::CFG_SCALE_X:     r_scale_x     <= i_cfg_wr_data;
                bgs_pkg::CFG_SCALE_Y:     r_scale_y     <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgs_pkg::ST_IDLE;
            r_cap_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap_en <= rd_en;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_slot <= r_i;
        if (r_cap_en) r_taps[r_cap_slot] <= r_rd_data;
        if (out_load) r_out_data <= r_res;
        case (r_state)
            bgs_pkg::ST_IDLE: begin
                r_u <= i_u;
                r_v <= i_v;
                r_i <= 2'd0;
                r_j <= 2'd0;
            end
            bgs_pkg::ST_SETUP: begin
                r_xi  <= xi_c;
                r_yi  <= yi_c;
                r_xf  <= xp[POS_FRAC_BITS-1:0];
                r_yf  <= yp[POS_FRAC_BITS-1:0];
                r_xhi <= hi_bound(r_grid_width, MAX_COLS);
                r_yhi <= hi_bound(r_grid_height, MAX_ROWS);
            end
            bgs_pkg::ST_READ: r_i <= r_i + 2'd1;
            bgs_pkg::ST_XWAIT: begin
                if (cu_done) begin
                    r_cols[r_j] <= cu_result[TW-1:0];
                    r_j <= r_j + 2'd1;
                end
            end
            bgs_pkg::ST_YWAIT: begin
                if (cu_done) begin
                    if (cu_result[bgs_pkg::RES_W-1] != cu_result[bgs_pkg::RES_W-2]) begin
                        r_res <= cu_result[bgs_pkg::RES_W-1] ? {1'b1, {(bgs_pkg::OUT_W-1){1'b0}}}
                                                             : {1'b0, {(bgs_pkg::OUT_W-1){1'b1}}};
                    end else begin
                        r_res <= cu_result[bgs_pkg::OUT_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        cu_start = 1'b0;
        out_load = 1'b0;
        case (r_state)
            bgs_pkg::ST_IDLE: begin
                if (in_acc && i_op == bgs_pkg::OP_QUERY) n_state = bgs_pkg::ST_SETUP;
            end
            bgs_pkg::ST_SETUP: n_state = bgs_pkg::ST_READ;
            bgs_pkg::ST_READ:  if (r_i == 2'd3) n_state = bgs_pkg::ST_LAST;
            bgs_pkg::ST_LAST:  n_state = bgs_pkg::ST_XSTART;
            bgs_pkg::ST_XSTART: begin
                cu_start = 1'b1;
                n_state  = bgs_pkg::ST_XWAIT;
            end
            bgs_pkg::ST_XWAIT: begin
                if (cu_done) n_state = (r_j == 2'd3) ? bgs_pkg::ST_YSTART : bgs_pkg::ST_READ;
            end
            bgs_pkg::ST_YSTART: begin
                cu_start = 1'b1;
                n_state  = bgs_pkg::ST_YWAIT;
            end
            bgs_pkg::ST_YWAIT: if (cu_done) n_state = bgs_pkg::ST_OUT;
            bgs_pkg::ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = bgs_pkg::ST_IDLE;
                end
            end
            default: n_state = bgs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == bgs_pkg::ST_YSTART) begin
            ta = r_cols[0];
            tb = r_cols[1];
            tc = r_cols[2];
            td = r_cols[3];
            tt = r_yf;
        end else begin
            ta = TW'(r_taps[0]);
            tb = TW'(r_taps[1]);
            tc = TW'(r_taps[2]);
            td = TW'(r_taps[3]);
            tt = r_xf;
        end
    end

    bgs_cubic #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cu_start),
        .i_a      (ta),
        .i_b      (tb),
        .i_c      (tc),
        .i_d      (td),
        .i_t      (tt),
        .o_done   (cu_done),
        .o_result (cu_result)
    );

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_out_data;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en)) else $error("memory read and write in the same cycle");
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cu_done |-> (r_state == bgs_pkg::ST_XWAIT || r_state == bgs_pkg::ST_YWAIT))
        else $error("cubic result arrived while not waiting");
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid) else $error("finished query not presented");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == bgs_pkg::ST_IDLE)) else $error("write started a query");
endmodule
